FILE: rtl/core/banked_memory_mapper_core_macros.svh
// Assertion macros for the banked memory mapper core.
`ifndef BANKED_MEMORY_MAPPER_CORE_MACROS_SVH
`define BANKED_MEMORY_MAPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define BMM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BMM_ASSERT_IMPL(label, ante, cons)

`define BMM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/bmm_pkg.sv
// Types, constants and helpers shared by the banked memory mapper.
package bmm_pkg;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned PHYS_W     = 20;
    localparam int unsigned PAGE_OFS_W = 13;
    localparam int unsigned TBL_IDX_W  = 5;
    localparam int unsigned TBL_DEPTH  = 32;
    localparam int unsigned BANK_W     = 2;

    localparam logic [DATA_W-1:0]    BOOT_PAGE   = 8'd7;
    localparam logic [TBL_IDX_W-1:0] BOOT_ENTRY  = 5'd7;
    localparam logic [ADDR_W-1:0]    ADDR_MAP    = 16'h0000;
    localparam logic [ADDR_W-1:0]    ADDR_IO     = 16'h0001;
    localparam logic [ADDR_W-1:0]    ADDR_FAST   = 16'hFFFA;
    localparam logic [2:0]           IO_WINDOW   = 3'b110;

    typedef enum logic [1:0] {
        TGT_DROP = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_IO   = 2'd2,
        TGT_REG  = 2'd3
    } target_t;

    function automatic logic [DATA_W-1:0] table_reset_value(input logic [TBL_IDX_W-1:0] idx);
        logic [DATA_W-1:0] v;
        v = {{(DATA_W-TBL_IDX_W){1'b0}}, idx};
        if (idx == BOOT_ENTRY)
        begin
            v = BOOT_PAGE;
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/bmm_in_if.sv
// Access channel into the mapper: valid/ready plus the CPU access fields.
interface bmm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [bmm_pkg::ADDR_W-1:0]  cpu_address;
    logic [bmm_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, action, cpu_address, write_data, input ready);
    modport sink   (input valid, action, cpu_address, write_data, output ready);
endinterface

FILE: rtl/core/bmm_out_if.sv
// Routed access channel out of the mapper: valid/ready plus the routing fields.
interface bmm_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  target;
    logic [bmm_pkg::PHYS_W-1:0]  phys_address;
    logic [bmm_pkg::BANK_W-1:0]  io_bank;
    logic [bmm_pkg::ADDR_W-1:0]  bus_address;
    logic                        is_write;
    logic [bmm_pkg::DATA_W-1:0]  out_data;
    logic [bmm_pkg::DATA_W-1:0]  fast_mode;

    modport source (output valid, target, phys_address, io_bank, bus_address, is_write,
                    out_data, fast_mode, input ready);
    modport sink   (input valid, target, phys_address, io_bank, bus_address, is_write,
                    out_data, fast_mode, output ready);
endinterface

FILE: rtl/core/banked_memory_mapper_core.sv
// Banked memory mapper: decodes one CPU bus access per beat and routes it.
//
//  channel  | modport | beat contents
//  ---------+---------+-------------------------------------------------------
//  access   | sink    | action, cpu_address, write_data
//  route    | source  | target, phys_address, io_bank, bus_address, is_write,
//           |         | out_data, fast_mode
//
// One beat per cycle unless the route side stalls; each result appears in the cycle after its access beat.
// Decode and the bank table read happen at the access edge, into the result register.
// The access side stays ready while the result register is empty or being drained.
// Reset restores the bank tables through per-entry valid bits; no clearing pass.
`include "banked_memory_mapper_core_macros.svh"

module banked_memory_mapper_core (
    input  logic      clk,
    input  logic      rst_n,
    bmm_in_if.sink    access,
    bmm_out_if.source route
);
    import bmm_pkg::*;

    logic [DATA_W-1:0]    table_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] tbl_valid_reg;

    logic [DATA_W-1:0]    map_control_reg, map_control_next;
    logic [DATA_W-1:0]    io_control_reg, io_control_next;
    logic                 page_c_is_ram_reg, page_c_is_ram_next;
    logic [DATA_W-1:0]    fast_byte_reg, fast_byte_next;

    logic                 out_valid_reg;
    target_t              target_reg, target_next;
    logic [BANK_W-1:0]    io_bank_reg, io_bank_next;
    logic [ADDR_W-1:0]    bus_address_reg;
    logic                 is_write_reg;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic                 use_tbl_reg, use_tbl_next;
    logic [DATA_W-1:0]    rd_mem_reg;
    logic                 rd_valid_reg;
    logic [TBL_IDX_W-1:0] rd_idx_reg, rd_idx;

    logic                 accept;
    logic                 tbl_we;
    logic [TBL_IDX_W-1:0] edit_idx;
    logic                 low_area, io_win, edit_hit;
    logic [DATA_W-1:0]    entry;

    assign accept   = access.valid && access.ready;
    assign access.ready = !out_valid_reg || route.ready;

    assign low_area = (access.cpu_address[ADDR_W-1:4] == '0);
    assign io_win   = !page_c_is_ram_reg && (access.cpu_address[ADDR_W-1:PAGE_OFS_W] == IO_WINDOW);
    assign edit_hit = map_control_reg[7] && low_area && access.cpu_address[3];
    assign edit_idx = {map_control_reg[5:4], access.cpu_address[2:0]};

    always_comb
    begin
        map_control_next   = map_control_reg;
        io_control_next    = io_control_reg;
        page_c_is_ram_next = page_c_is_ram_reg;
        fast_byte_next     = fast_byte_reg;
        target_next        = TGT_RAM;
        io_bank_next       = '0;
        out_data_next      = '0;
        use_tbl_next       = 1'b0;
        tbl_we             = 1'b0;
        rd_idx             = {map_control_reg[1:0], access.cpu_address[ADDR_W-1:PAGE_OFS_W]};
        if (access.action)
        begin
            out_data_next = access.write_data;
            if (access.cpu_address == ADDR_FAST)
            begin
                fast_byte_next = access.write_data;
            end
            if (low_area)
            begin
                if (edit_hit)
                begin
                    tbl_we      = accept;
                    target_next = TGT_REG;
                end
                else if (access.cpu_address == ADDR_MAP)
                begin
                    map_control_next = access.write_data;
                    target_next      = TGT_REG;
                end
                else if (access.cpu_address == ADDR_IO)
                begin
                    io_control_next    = access.write_data;
                    page_c_is_ram_next = access.write_data[2];
                    target_next        = TGT_REG;
                end
                else
                begin
                    target_next = TGT_DROP;
                end
            end
            else if (io_win)
            begin
                target_next  = TGT_IO;
                io_bank_next = io_control_reg[BANK_W-1:0];
            end
        end
        else
        begin
            if (io_win)
            begin
                target_next  = TGT_IO;
                io_bank_next = io_control_reg[BANK_W-1:0];
            end
            else if (edit_hit)
            begin
                target_next  = TGT_REG;
                use_tbl_next = 1'b1;
                rd_idx       = edit_idx;
            end
            else if (access.cpu_address == ADDR_MAP)
            begin
                target_next   = TGT_REG;
                out_data_next = map_control_reg;
            end
            else if (access.cpu_address == ADDR_IO)
            begin
                target_next   = TGT_REG;
                out_data_next = io_control_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_mem[edit_idx] <= access.write_data;
        end
        if (accept)
        begin
            rd_mem_reg      <= table_mem[rd_idx];
            rd_idx_reg      <= rd_idx;
            target_reg      <= target_next;
            io_bank_reg     <= io_bank_next;
            bus_address_reg <= access.cpu_address;
            is_write_reg    <= access.action;
            out_data_reg    <= out_data_next;
            use_tbl_reg     <= use_tbl_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg     <= '0;
            rd_valid_reg      <= 1'b0;
            map_control_reg   <= '0;
            io_control_reg    <= '0;
            page_c_is_ram_reg <= 1'b0;
            fast_byte_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (tbl_we)
            begin
                tbl_valid_reg[edit_idx] <= 1'b1;
            end
            if (accept)
            begin
                rd_valid_reg      <= tbl_valid_reg[rd_idx];
                map_control_reg   <= map_control_next;
                io_control_reg    <= io_control_next;
                page_c_is_ram_reg <= page_c_is_ram_next;
                fast_byte_reg     <= fast_byte_next;
                out_valid_reg     <= 1'b1;
            end
            else if (route.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign entry = rd_valid_reg ? rd_mem_reg : table_reset_value(rd_idx_reg);

    assign route.valid        = out_valid_reg;
    assign route.target       = target_reg;
    assign route.phys_address = (target_reg == TGT_RAM)
                                ? {entry[PHYS_W-PAGE_OFS_W-1:0], bus_address_reg[PAGE_OFS_W-1:0]}
                                : '0;
    assign route.io_bank      = io_bank_reg;
    assign route.bus_address  = bus_address_reg;
    assign route.is_write     = is_write_reg;
    assign route.out_data     = use_tbl_reg ? entry : out_data_reg;
    assign route.fast_mode    = fast_byte_reg;

    `BMM_ASSERT_NEXT(a_result_follows, accept, route.valid)
    `BMM_ASSERT_IMPL(a_bank_only_io, route.valid && (route.target != TGT_IO), route.io_bank == '0)
    `BMM_ASSERT_NEXT(a_map_write, accept && access.action && (access.cpu_address == ADDR_MAP), map_control_reg == $past(access.write_data))
    `BMM_ASSERT_IMPL(a_tbl_read_is_reg, route.valid && use_tbl_reg, (route.target == TGT_REG) && !route.is_write)
    `BMM_ASSERT_NEXT(a_stall_holds, route.valid && !route.ready, $stable(target_reg) && $stable(fast_byte_reg))

endmodule

FILE: tb/sv/tb.sv
// Testbench for banked_memory_mapper_core: directed table plus random bus accesses, scoreboarded.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmm_pkg::*;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1125;
    localparam int N_CALM      = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 1000;
    localparam int EDIT_BIT    = 7;
    localparam logic [ADDR_W-1:0] CTRL_TOP = 16'h0010;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } access_t;

    typedef struct packed {
        target_t           target;
        logic [PHYS_W-1:0] phys;
        logic [BANK_W-1:0] bank;
        logic [ADDR_W-1:0] bus;
        logic              is_write;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] fast;
    } route_t;

    typedef struct packed {
        access_t acc;
        logic    typed;
        route_t  want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bmm_in_if  access_ch ();
    bmm_out_if route_ch ();

    banked_memory_mapper_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access_ch),
        .route  (route_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [DATA_W-1:0] page_map [TBL_DEPTH];
    logic [DATA_W-1:0] map_ctl;
    logic [DATA_W-1:0] io_ctl;
    logic              c_ram;
    logic [DATA_W-1:0] fast_byte;

    route_t pending_routes [$];
    int     fail_count = 0;
    int     items_sent = 0;
    int     routes_seen = 0;
    int     target_hits [4] = '{0, 0, 0, 0};
    bit     calm = 1'b0;
    bit     hold_done = 1'b0;

    function automatic route_t predict_route(input access_t a);
        route_t           r;
        logic [TBL_IDX_W-1:0] edit_idx;
        logic [TBL_IDX_W-1:0] act_idx;
        logic             io_hit;
        logic             edit_hit;
        logic             to_ram;
        r = '{TGT_DROP, '0, '0, a.addr, a.action, '0, '0};
        edit_idx = {map_ctl[5:4], a.addr[2:0]};
        act_idx  = {map_ctl[1:0], a.addr[15:13]};
        io_hit   = !c_ram && (a.addr[15:13] == IO_WINDOW);
        edit_hit = map_ctl[EDIT_BIT] && (a.addr[15:3] == 13'd1);
        to_ram   = 1'b0;
        if (a.action)
        begin
            r.data = a.data;
            if (a.addr == ADDR_FAST)
                fast_byte = a.data;
            if (a.addr < CTRL_TOP)
            begin
                r.target = TGT_REG;
                if (edit_hit)
                    page_map[edit_idx] = a.data;
                else if (a.addr == ADDR_MAP)
                    map_ctl = a.data;
                else if (a.addr == ADDR_IO)
                begin
                    io_ctl = a.data;
                    c_ram  = a.data[2];
                end
                else
                    r.target = TGT_DROP;
            end
            else if (io_hit)
                r.target = TGT_IO;
            else
                to_ram = 1'b1;
        end
        else
        begin
            if (io_hit)
                r.target = TGT_IO;
            else if (edit_hit)
            begin
                r.target = TGT_REG;
                r.data   = page_map[edit_idx];
            end
            else if (a.addr == ADDR_MAP)
            begin
                r.target = TGT_REG;
                r.data   = map_ctl;
            end
            else if (a.addr == ADDR_IO)
            begin
                r.target = TGT_REG;
                r.data   = io_ctl;
            end
            else
                to_ram = 1'b1;
        end
        if (r.target == TGT_IO)
            r.bank = io_ctl[1:0];
        if (to_ram)
        begin
            r.target = TGT_RAM;
            r.phys   = {page_map[act_idx][PHYS_W-PAGE_OFS_W-1:0], a.addr[PAGE_OFS_W-1:0]};
        end
        r.fast = fast_byte;
        return r;
    endfunction

    function automatic access_t make_access();
        access_t a;
        int      pick;
        pick     = $urandom_range(0, 99);
        a.action = 1'($urandom_range(0, 1));
        a.data   = DATA_W'($urandom_range(0, 255));
        a.addr   = ADDR_W'($urandom_range(0, 65535));
        if (pick < 10)
        begin
            a.action = 1'b1;
            a.addr   = ADDR_MAP;
            if ($urandom_range(0, 2) != 0)
                a.data[EDIT_BIT] = 1'b1;
        end
        else if (pick < 25)
            a.addr = ADDR_W'($urandom_range(8, 15));
        else if (pick < 31)
            a.addr = ADDR_IO;
        else if (pick < 37)
            a.addr = ADDR_W'($urandom_range(0, 15));
        else if (pick < 42)
            a.addr = ADDR_FAST;
        else if (pick < 55)
            a.addr = ADDR_W'($urandom_range(16'hC000, 16'hDFFF));
        return a;
    endfunction

    task automatic offer(input access_t a, input logic typed, input route_t want);
        route_t guess;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            access_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        access_ch.valid       <= 1'b1;
        access_ch.action      <= a.action;
        access_ch.cpu_address <= a.addr;
        access_ch.write_data  <= a.data;
        do
            @(posedge clk);
        while (!access_ch.ready);
        guess = predict_route(a);
        pending_routes.push_back(typed ? want : guess);
        items_sent++;
    endtask

    task automatic check_route(input route_t exp);
        if (route_ch.target !== exp.target)
        begin
            $error("target: expected %0d, got %0d", exp.target, route_ch.target);
            fail_count++;
        end
        if (route_ch.phys_address !== exp.phys)
        begin
            $error("phys_address: expected %h, got %h", exp.phys, route_ch.phys_address);
            fail_count++;
        end
        if (route_ch.io_bank !== exp.bank)
        begin
            $error("io_bank: expected %0d, got %0d", exp.bank, route_ch.io_bank);
            fail_count++;
        end
        if (route_ch.bus_address !== exp.bus)
        begin
            $error("bus_address: expected %h, got %h", exp.bus, route_ch.bus_address);
            fail_count++;
        end
        if (route_ch.is_write !== exp.is_write)
        begin
            $error("is_write: expected %0d, got %0d", exp.is_write, route_ch.is_write);
            fail_count++;
        end
        if (route_ch.out_data !== exp.data)
        begin
            $error("out_data: expected %h, got %h", exp.data, route_ch.out_data);
            fail_count++;
        end
        if (route_ch.fast_mode !== exp.fast)
        begin
            $error("fast_mode: expected %h, got %h", exp.fast, route_ch.fast_mode);
            fail_count++;
        end
    endtask

    initial
    begin : route_sink
        int stall_left;
        stall_left = 0;
        route_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (route_ch.valid && route_ch.ready)
            begin
                if (pending_routes.size() == 0)
                begin
                    $error("route beat with no access pending: bus_address %h",
                           route_ch.bus_address);
                    fail_count++;
                end
                else
                begin
                    check_route(pending_routes.pop_front());
                    routes_seen++;
                    target_hits[route_ch.target]++;
                end
            end
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                route_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                route_ch.ready <= 1'b0;
            end
            else
                route_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((access_ch.valid && access_ch.ready) || (route_ch.valid && route_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        step_t  steps [N_DIRECTED];
        route_t no_route;
        no_route = '{TGT_DROP, 20'h0, 2'd0, 16'h0, 1'b0, 8'h0, 8'h0};
        steps = '{
            '{'{1'b0, 16'h0000, 8'h00}, 1'b1, '{TGT_REG, 20'h0, 2'd0, 16'h0000, 1'b0, 8'h00, 8'h00}},
            '{'{1'b0, 16'h0001, 8'hFF}, 1'b1, '{TGT_REG, 20'h0, 2'd0, 16'h0001, 1'b0, 8'h00, 8'h00}},
            '{'{1'b0, 16'hC000, 8'h00}, 1'b1, '{TGT_IO, 20'h0, 2'd0, 16'hC000, 1'b0, 8'h00, 8'h00}},
            '{'{1'b0, 16'hE000, 8'h00}, 1'b1,
              '{TGT_RAM, 20'h0E000, 2'd0, 16'hE000, 1'b0, 8'h00, 8'h00}},
            '{'{1'b0, 16'hFFFF, 8'h00}, 1'b1,
              '{TGT_RAM, 20'h0FFFF, 2'd0, 16'hFFFF, 1'b0, 8'h00, 8'h00}},
            '{'{1'b1, 16'hFFFA, 8'hFF}, 1'b1,
              '{TGT_RAM, 20'h0FFFA, 2'd0, 16'hFFFA, 1'b1, 8'hFF, 8'hFF}},
            '{'{1'b1, 16'h0005, 8'hAA}, 1'b1, '{TGT_DROP, 20'h0, 2'd0, 16'h0005, 1'b1, 8'hAA, 8'hFF}},
            '{'{1'b0, 16'h0005, 8'h00}, 1'b0, no_route},
            '{'{1'b1, 16'h0000, 8'hB1}, 1'b0, no_route},
            '{'{1'b1, 16'h0008, 8'hFF}, 1'b0, no_route},
            '{'{1'b1, 16'h000F, 8'h00}, 1'b0, no_route},
            '{'{1'b0, 16'h0008, 8'h00}, 1'b0, no_route},
            '{'{1'b0, 16'h000F, 8'h00}, 1'b0, no_route},
            '{'{1'b1, 16'h0001, 8'h07}, 1'b0, no_route},
            '{'{1'b0, 16'hC123, 8'h00}, 1'b0, no_route},
            '{'{1'b0, 16'h0001, 8'h00}, 1'b0, no_route},
            '{'{1'b1, 16'h0000, 8'h03}, 1'b0, no_route},
            '{'{1'b0, 16'h0008, 8'h00}, 1'b0, no_route},
            '{'{1'b0, 16'hE000, 8'h00}, 1'b0, no_route},
            '{'{1'b1, 16'h0001, 8'h01}, 1'b0, no_route},
            '{'{1'b1, 16'hDFFF, 8'h5A}, 1'b0, no_route},
            '{'{1'b1, 16'h0000, 8'h00}, 1'b0, no_route},
            '{'{1'b1, 16'hFFFA, 8'h00}, 1'b0, no_route},
            '{'{1'b1, 16'hFFFF, 8'hFF}, 1'b0, no_route},
            '{'{1'b0, 16'hBFFF, 8'h00}, 1'b0, no_route}
        };

        for (int i = 0; i < TBL_DEPTH; i++)
            page_map[i] = DATA_W'(i);
        page_map[BOOT_ENTRY] = BOOT_PAGE;
        map_ctl   = '0;
        io_ctl    = '0;
        c_ram     = 1'b0;
        fast_byte = '0;

        access_ch.valid       <= 1'b0;
        access_ch.action      <= 1'b0;
        access_ch.cpu_address <= '0;
        access_ch.write_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
            offer(steps[i].acc, steps[i].typed, steps[i].want);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - N_CALM)
                calm = 1'b1;
            offer(make_access(), 1'b0, no_route);
        end
        access_ch.valid <= 1'b0;

        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Routed %0d accesses: %0d dropped, %0d RAM, %0d I/O, %0d register.",
                 routes_seen, target_hits[0], target_hits[1], target_hits[2], target_hits[3]);
        $display("Covered table edits, control reads and writes, fast-mode latches, a long stall.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
